[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("assertion failed: invariant violated");

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: implication violated");

`endif

[rtl/core/lkvc_pkg.sv]
// ----------------------------------------------------------------------------
// lkvc_pkg
// Request and response types and fixed constants of the LRU key-value cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

   localparam int DATA_W = 32;
   localparam int CAP_W  = 5;

   localparam logic              CMD_GET    = 1'b0;
   localparam logic              CMD_PUT    = 1'b1;
   localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;
   localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;

   typedef struct packed {
      logic                     command;
      logic signed [DATA_W-1:0] lookup_key;
      logic signed [DATA_W-1:0] write_value;
   } req_type;

   typedef struct packed {
      logic                     hit;
      logic signed [DATA_W-1:0] read_value;
      logic                     evicted;
      logic signed [DATA_W-1:0] evicted_key;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/core/lkvc_ram.sv]
// ----------------------------------------------------------------------------
// lkvc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/lru_key_value_cache.sv]
// A new request is taken only in idle, after the response of the last one is registered;
// a stalled earlier response holds the finish step. One pass over the entry RAM, one
// entry per cycle, matches the key and finds the oldest; a second pass, skipped on a get
// miss, rewrites the rank of each valid entry, so both passes grow with the table size.
// Reset (synchronous) clears valid bits, use count and control; capacity resets to 16.
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lru_key_value_cache
   import lkvc_pkg::*;
#(
   parameter int MAX_ENTRIES = 16,
   parameter int KEY_BITS    = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_type          req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_payload,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [CAP_W-1:0] csr_data
);

   localparam int IDX_W   = $clog2(MAX_ENTRIES);
   localparam int RANK_W  = IDX_W;
   localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
   localparam int USED_W  = $clog2(MAX_ENTRIES + 1);
   localparam int ENTRY_W = KEY_BITS + DATA_W + RANK_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic [CAP_W-1:0]       cap_ff, cap_in;
   logic [USED_W-1:0]      used_ff, used_in;
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic                   hit_ff, hit_in;
   logic                   lru_have_ff, lru_have_in;
   logic                   tgt_ok_ff, tgt_ok_in;
   logic                   evict_ff, evict_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Payload registers, no reset.
   logic                   cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [DATA_W-1:0]      val_ff, val_in;
   logic [IDX_W-1:0]       hit_idx_ff, hit_idx_in;
   logic [RANK_W-1:0]      hit_rank_ff, hit_rank_in;
   logic [DATA_W-1:0]      hit_val_ff, hit_val_in;
   logic [IDX_W-1:0]       lru_idx_ff, lru_idx_in;
   logic [RANK_W-1:0]      lru_rank_ff, lru_rank_in;
   logic [KEY_BITS-1:0]    lru_key_ff, lru_key_in;
   logic [IDX_W-1:0]       tgt_ff, tgt_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   ram_we;
   logic [IDX_W-1:0]       ram_raddr;
   logic [ENTRY_W-1:0]     ram_wdata;
   logic [ENTRY_W-1:0]     ram_rdata;

   logic [KEY_BITS-1:0]    rd_key;
   logic [DATA_W-1:0]      rd_val;
   logic [RANK_W-1:0]      rd_rank;
   logic                   rd_entry_valid;

   logic [USED_W-1:0]      eff_cap;
   logic [IDX_W-1:0]       free_idx;
   logic                   free_have;
   logic                   put_miss;
   logic                   evict;
   logic                   is_tgt;
   logic                   bump;
   logic                   last_issued;

   lkvc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (rd_idx_ff),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_key         = ram_rdata[ENTRY_W-1 -: KEY_BITS];
   assign rd_val         = ram_rdata[RANK_W +: DATA_W];
   assign rd_rank        = ram_rdata[RANK_W-1:0];
   assign rd_entry_valid = valid_ff[rd_idx_ff];
   assign ram_raddr      = cnt_ff[IDX_W-1:0];
   assign last_issued    = (cnt_ff == CNT_W'(MAX_ENTRIES));

   // Capacity zero acts as one, and anything above the table size saturates.
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = USED_W'(1);
      end else if (32'(cap_ff) > 32'(MAX_ENTRIES)) begin
         eff_cap = USED_W'(MAX_ENTRIES);
      end else begin
         eff_cap = USED_W'(cap_ff);
      end
   end

   // The lowest-numbered free slot wins, so scan from the top down.
   always_comb begin
      free_idx  = '0;
      free_have = 1'b0;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx  = IDX_W'(i);
            free_have = 1'b1;
         end
      end
   end

   assign put_miss = (cmd_ff == CMD_PUT) && !hit_ff;
   assign evict    = put_miss && (used_ff >= eff_cap) && lru_have_ff;

   // On a hit only entries more recent than the hit entry age; on a fill all do.
   assign is_tgt = (rd_idx_ff == tgt_ff);
   assign bump   = rd_entry_valid && !is_tgt && (!hit_ff || (rd_rank < hit_rank_ff));

   always_comb begin
      ram_we    = 1'b0;
      ram_wdata = ram_rdata;
      if (state_ff == ST_UPDATE && rd_vld_ff) begin
         ram_we = rd_entry_valid;
         if (is_tgt) begin
            ram_wdata = {(put_miss ? key_ff : rd_key),
                         ((cmd_ff == CMD_PUT) ? val_ff : rd_val),
                         RANK_W'(0)};
         end else if (bump) begin
            ram_wdata = {rd_key, rd_val, RANK_W'(rd_rank + 1'b1)};
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      cap_in       = cap_ff;
      used_in      = used_ff;
      valid_in     = valid_ff;
      hit_in       = hit_ff;
      lru_have_in  = lru_have_ff;
      tgt_ok_in    = tgt_ok_ff;
      evict_in     = evict_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      hit_idx_in   = hit_idx_ff;
      hit_rank_in  = hit_rank_ff;
      hit_val_in   = hit_val_ff;
      lru_idx_in   = lru_idx_ff;
      lru_rank_in  = lru_rank_ff;
      lru_key_in   = lru_key_ff;
      tgt_in       = tgt_ff;
      rsp_in       = rsp_ff;

      if (csr_valid && csr_ready) begin
         cap_in = csr_data;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in      = req_payload.command;
               key_in      = KEY_BITS'($unsigned(req_payload.lookup_key));
               val_in      = $unsigned(req_payload.write_value);
               hit_in      = 1'b0;
               lru_have_in = 1'b0;
               cnt_in      = '0;
               state_in    = ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (!last_issued) begin
               rd_vld_in = 1'b1;
               rd_idx_in = cnt_ff[IDX_W-1:0];
               cnt_in    = CNT_W'(cnt_ff + 1'b1);
            end
            if (rd_vld_ff && rd_entry_valid) begin
               if (!hit_ff && rd_key == key_ff) begin
                  hit_in      = 1'b1;
                  hit_idx_in  = rd_idx_ff;
                  hit_rank_in = rd_rank;
                  hit_val_in  = rd_val;
               end
               if (!lru_have_ff || rd_rank > lru_rank_ff) begin
                  lru_have_in = 1'b1;
                  lru_idx_in  = rd_idx_ff;
                  lru_rank_in = rd_rank;
                  lru_key_in  = rd_key;
               end
            end
            if (last_issued) begin
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            evict_in  = evict;
            tgt_ok_in = hit_ff || evict || (put_miss && free_have);
            if (hit_ff) begin
               tgt_in = hit_idx_ff;
            end else if (evict) begin
               tgt_in = lru_idx_ff;
            end else begin
               tgt_in = free_idx;
            end
            // An eviction reuses the slot, so the count only grows on a free fill.
            if (put_miss && (evict || free_have)) begin
               if (evict) begin
                  valid_in[lru_idx_ff] = 1'b1;
               end else begin
                  valid_in[free_idx] = 1'b1;
                  used_in            = USED_W'(used_ff + 1'b1);
               end
            end
            cnt_in   = '0;
            state_in = (hit_ff || evict || (put_miss && free_have)) ? ST_UPDATE : ST_FINISH;
         end

         ST_UPDATE: begin
            if (!last_issued) begin
               rd_vld_in = 1'b1;
               rd_idx_in = cnt_ff[IDX_W-1:0];
               cnt_in    = CNT_W'(cnt_ff + 1'b1);
            end
            if (last_issued) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.hit         = hit_ff;
               rsp_in.read_value  = (cmd_ff == CMD_PUT) ? '0 :
                                    (hit_ff ? hit_val_ff : MISS_VALUE);
               rsp_in.evicted     = evict_ff;
               rsp_in.evicted_key = evict_ff ? DATA_W'(lru_key_ff) : '0;
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rd_idx_ff    <= '0;
         cap_ff       <= CAP_RESET;
         used_ff      <= '0;
         valid_ff     <= '0;
         hit_ff       <= 1'b0;
         lru_have_ff  <= 1'b0;
         tgt_ok_ff    <= 1'b0;
         evict_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rd_vld_ff    <= rd_vld_in;
         rd_idx_ff    <= rd_idx_in;
         cap_ff       <= cap_in;
         used_ff      <= used_in;
         valid_ff     <= valid_in;
         hit_ff       <= hit_in;
         lru_have_ff  <= lru_have_in;
         tgt_ok_ff    <= tgt_ok_in;
         evict_ff     <= evict_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
      hit_idx_ff  <= hit_idx_in;
      hit_rank_ff <= hit_rank_in;
      hit_val_ff  <= hit_val_in;
      lru_idx_ff  <= lru_idx_in;
      lru_rank_ff <= lru_rank_in;
      lru_key_ff  <= lru_key_in;
      tgt_ff      <= tgt_in;
      rsp_ff      <= rsp_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready   = 1'b1;

   `ASSERT_ALWAYS(a_used_bound, used_ff <= USED_W'(MAX_ENTRIES))
   `ASSERT_ALWAYS(a_used_matches_valid, $countones(valid_ff) == int'(used_ff))
   `ASSERT_IMPLIES(a_write_only_valid, ram_we, valid_ff[rd_idx_ff] && tgt_ok_ff)
   `ASSERT_IMPLIES(a_evict_needs_entry, state_ff == ST_DECIDE && evict, used_ff != '0)

endmodule

`default_nettype wire

[tb/lru_key_value_cache_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_test
// Drives get and put requests into the LRU cache through several capacity
// settings and idling patterns. A shadow copy of the cache, kept in the
// testbench, predicts every response and the monitor checks it field by field.
// ----------------------------------------------------------------------------

module lru_key_value_cache_test
   import lkvc_pkg::*;
();

   localparam int SLOTS          = 16;
   localparam int DRAIN_CYCLES   = 2 * SLOTS + 8;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASES         = 6;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   req_type          req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   rsp_type          rsp_payload;
   logic             csr_valid   = 1'b0;
   logic             csr_ready;
   logic [CAP_W-1:0] csr_data    = '0;

   // Shadow copy of the cache contents.
   logic [DATA_W-1:0] cache_key   [SLOTS];
   logic [DATA_W-1:0] cache_value [SLOTS];
   logic              cache_live  [SLOTS];
   int unsigned       cache_age   [SLOTS];
   int                cache_fill  = 0;
   int                cache_limit = int'(CAP_RESET);

   req_type queued_requests[$];
   rsp_type due_responses[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int quiet_cycles  = 0;
   int fault_count   = 0;
   int request_count = 0;
   int hit_count     = 0;
   int evict_count   = 0;
   int setting_count = 0;

   int phase_cap  [PHASES] = '{5, 1, 9, 16, 3, 12};
   int phase_send [PHASES] = '{33, 33, 73, 73, 0, 0};
   int phase_recv [PHASES] = '{73, 73, 33, 33, 0, 0};
   int phase_len  [PHASES] = '{190, 150, 200, 210, 200, 200};

   lru_key_value_cache #(
      .MAX_ENTRIES (SLOTS),
      .KEY_BITS    (DATA_W)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always #10 clock = ~clock;

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         cache_key[i]   = '0;
         cache_value[i] = '0;
         cache_live[i]  = 1'b0;
         cache_age[i]   = 0;
      end
   end

   // Slot s becomes the most recent; every live slot younger than its old age
   // grows one step older.
   function automatic void refresh_age(int s, int unsigned old_age);
      for (int i = 0; i < SLOTS; i++) begin
         if (i != s && cache_live[i] && cache_age[i] < old_age) begin
            cache_age[i]++;
         end
      end
      cache_age[s] = 0;
   endfunction

   function automatic rsp_type cache_access(req_type r);
      rsp_type     o;
      int          found;
      int          slot;
      int          room;
      int unsigned oldest;
      o      = '0;
      found  = -1;
      slot   = -1;
      oldest = 0;
      for (int i = 0; i < SLOTS; i++) begin
         if (found < 0 && cache_live[i] && cache_key[i] == r.lookup_key) begin
            found = i;
         end
      end
      if (found >= 0) begin
         o.hit = 1'b1;
         refresh_age(found, cache_age[found]);
         if (r.command == CMD_GET) begin
            o.read_value = cache_value[found];
         end else begin
            cache_value[found] = r.write_value;
         end
      end else if (r.command == CMD_GET) begin
         o.read_value = MISS_VALUE;
      end else begin
         room = (cache_limit == 0) ? 1 : (cache_limit > SLOTS) ? SLOTS : cache_limit;
         if (cache_fill >= room) begin
            for (int i = 0; i < SLOTS; i++) begin
               if (cache_live[i] && (slot < 0 || cache_age[i] > oldest)) begin
                  slot   = i;
                  oldest = cache_age[i];
               end
            end
            if (slot >= 0) begin
               o.evicted     = 1'b1;
               o.evicted_key = cache_key[slot];
               cache_live[slot] = 1'b0;
               cache_fill--;
            end
         end
         // Without an eviction the lowest free slot is taken.
         for (int i = 0; i < SLOTS; i++) begin
            if (slot < 0 && !cache_live[i]) begin
               slot = i;
            end
         end
         if (slot >= 0) begin
            refresh_age(slot, 32'hFFFF_FFFF);
            cache_key[slot]   = r.lookup_key;
            cache_value[slot] = r.write_value;
            cache_live[slot]  = 1'b1;
            cache_fill++;
         end
      end
      return o;
   endfunction

   function automatic req_type make_request(logic cmd, logic [31:0] key, logic [31:0] value);
      req_type r;
      r.command     = cmd;
      r.lookup_key  = key;
      r.write_value = value;
      return r;
   endfunction

   // Driver: a request that is held by stall keeps its payload.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            due_responses.push_back(cache_access(req_payload));
            request_count++;
            if (due_responses[$].hit) hit_count++;
            if (due_responses[$].evicted) evict_count++;
         end
         if (!(req_valid && req_stall)) begin
            if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid   <= 1'b1;
               req_payload <= queued_requests.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each accepted response with the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_responses.size() == 0) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("unexpected response: hit %0b read %h evicted %0b key %h",
                           rsp_payload.hit, rsp_payload.read_value,
                           rsp_payload.evicted, rsp_payload.evicted_key);
               end
            end else begin
               if (rsp_payload.hit !== due_responses[0].hit
                   || rsp_payload.read_value !== due_responses[0].read_value
                   || rsp_payload.evicted !== due_responses[0].evicted
                   || rsp_payload.evicted_key !== due_responses[0].evicted_key) begin
                  fault_count++;
                  if (fault_count <= 10) begin
                     $display("mismatch: expected hit %0b read %h evicted %0b key %h",
                              due_responses[0].hit, due_responses[0].read_value,
                              due_responses[0].evicted, due_responses[0].evicted_key);
                     $display("          actual   hit %0b read %h evicted %0b key %h",
                              rsp_payload.hit, rsp_payload.read_value,
                              rsp_payload.evicted, rsp_payload.evicted_key);
                  end
               end
               void'(due_responses.pop_front());
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Watchdog: a long stretch without any handshake means the block hung.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("lru_key_value_cache_test NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid   <= 1'b0;
      cache_limit = int'(cap);
      setting_count++;
   endtask

   // Waits at falling edges so the queues are read after the clocked blocks ran.
   task automatic wait_drained();
      do @(negedge clock);
      while (queued_requests.size() != 0 || req_valid || due_responses.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      logic [DATA_W-1:0] key_pool[$];
      req_type           r;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle_pct = phase_send[0];
      recv_idle_pct = phase_recv[0];
      write_capacity(CAP_W'(2));
      @(negedge clock);

      // Two entries only: fills, hits, updates, evictions and extreme keys.
      queued_requests.push_back(make_request(CMD_GET, 32'h8000_0000, 32'h1234_5678));
      queued_requests.push_back(make_request(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF));
      queued_requests.push_back(make_request(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000));
      queued_requests.push_back(make_request(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF));
      queued_requests.push_back(make_request(CMD_PUT, 32'h0000_0000, 32'h0000_0000));
      queued_requests.push_back(make_request(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000));
      queued_requests.push_back(make_request(CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF));
      queued_requests.push_back(make_request(CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0001));
      queued_requests.push_back(make_request(CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF));
      queued_requests.push_back(make_request(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000));
      queued_requests.push_back(make_request(CMD_PUT, 32'h0000_0001, 32'hA5A5_A5A5));
      queued_requests.push_back(make_request(CMD_PUT, 32'h8000_0001, 32'h5A5A_5A5A));
      queued_requests.push_back(make_request(CMD_GET, 32'h0000_0001, 32'h0000_0000));
      queued_requests.push_back(make_request(CMD_GET, 32'h8000_0001, 32'h0000_0000));
      queued_requests.push_back(make_request(CMD_GET, 32'h8000_0000, 32'h0000_0000));
      queued_requests.push_back(make_request(CMD_PUT, 32'h8000_0001, 32'h7FFF_FFFF));
      queued_requests.push_back(make_request(CMD_PUT, 32'hFFFF_FFFE, 32'h8000_0000));
      queued_requests.push_back(make_request(CMD_GET, 32'hFFFF_FFFE, 32'hFFFF_FFFF));
      wait_drained();

      // The cache is never reset between phases, so lowering the capacity leaves the
      // cache fuller than the new limit and every put miss must still evict.
      for (int p = 0; p < PHASES; p++) begin
         send_idle_pct = phase_send[p];
         recv_idle_pct = phase_recv[p];
         write_capacity(CAP_W'(phase_cap[p]));
         @(negedge clock);
         key_pool.delete();
         repeat (phase_cap[p] + 3) begin
            case ($urandom_range(15))
               0:       key_pool.push_back(32'h8000_0000);
               1:       key_pool.push_back(32'h7FFF_FFFF);
               2:       key_pool.push_back(32'h0000_0000);
               3:       key_pool.push_back(32'hFFFF_FFFF);
               default: key_pool.push_back($urandom);
            endcase
         end
         repeat (phase_len[p]) begin
            r.command = ($urandom_range(99) < 55) ? CMD_PUT : CMD_GET;
            if ($urandom_range(99) < 85) begin
               r.lookup_key = key_pool[$urandom_range(key_pool.size() - 1)];
            end else begin
               r.lookup_key = $urandom;
            end
            case ($urandom_range(7))
               0:       r.write_value = 32'h8000_0000;
               1:       r.write_value = 32'h7FFF_FFFF;
               default: r.write_value = $urandom;
            endcase
            queued_requests.push_back(r);
         end
         wait_drained();
      end

      if (due_responses.size() != 0) begin
         fault_count++;
         $display("%0d responses never arrived", due_responses.size());
      end
      $display("Covered %0d requests with %0d hits and %0d evictions", request_count,
               hit_count, evict_count);
      $display("across %0d capacity settings and three idling patterns", setting_count);
      if (fault_count == 0) begin
         $display("lru_key_value_cache_test OK");
      end else begin
         $display("lru_key_value_cache_test NOT OK");
      end
      $finish;
   end

endmodule
